@@ rtl/frr_pkg.sv @@
// ----------------------------------------------------------------------------
// frr_pkg: shared constants for the fragment reassembler
// Request codes, result codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package frr_pkg;

   localparam int SESSIONS_DEF      = 4;
   localparam int MAX_FRAGMENTS_DEF = 32;
   localparam int MAX_PAYLOAD_DEF   = 256;

   localparam int CNT_W     = 6;   // frag_count width, also fragment counters
   localparam int FLEN_W    = 9;   // frag_length width
   localparam int MSGLEN_W  = 14;
   localparam int MSGLEN_MAX = 16383;
   localparam int TIMEOUT_W = 16;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

   typedef logic [1:0] req_code_type;
   localparam req_code_type REQ_FRAG  = 2'd0;
   localparam req_code_type REQ_TICK  = 2'd1;
   localparam req_code_type REQ_DRAIN = 2'd2;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_COMPLETE = 2'd0;
   localparam kind_type KIND_DATA     = 2'd1;
   localparam kind_type KIND_DROP     = 2'd2;

   localparam int CSR_AW = 3;
   localparam logic CSR_IDX_TIMEOUT = 1'b0;

endpackage

@@ rtl/frr_if.sv @@
// ----------------------------------------------------------------------------
// frr_req_if / frr_rsp_if: valid/ready channels of the fragment reassembler
// One transfer at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface frr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] seq_number;
   logic [7:0]  command;
   logic [4:0]  frag_index;
   logic [5:0]  frag_count;
   logic [8:0]  frag_length;
   logic [7:0]  payload_byte;
   logic        byte_last;
   logic [31:0] now_ms;

   modport source (output valid, req_type, seq_number, command, frag_index, frag_count,
                   frag_length, payload_byte, byte_last, now_ms, input ready);
   modport sink (input valid, req_type, seq_number, command, frag_index, frag_count,
                 frag_length, payload_byte, byte_last, now_ms, output ready);
endinterface

interface frr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [15:0] msg_seq;
   logic [7:0]  msg_command;
   logic [13:0] msg_length;
   logic [7:0]  data_byte;
   logic        data_last;

   modport source (output valid, result_kind, msg_seq, msg_command, msg_length,
                   data_byte, data_last, input ready);
   modport sink (input valid, result_kind, msg_seq, msg_command, msg_length,
                 data_byte, data_last, output ready);
endinterface

@@ rtl/frr_ram.sv @@
// ----------------------------------------------------------------------------
// frr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module frr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/fragment_reassembler.sv @@
// ----------------------------------------------------------------------------
// fragment_reassembler: rebuilds messages from byte-wide fragment transfers
// Session table in flops, piece lengths and piece bytes in two RAMs.
// ----------------------------------------------------------------------------
// Usage:
//  req_ch carries one transfer per item: a fragment byte, an expiry tick or a
//  drain request. rsp_ch returns complete, data and drop results, at most one
//  per item. csr_* is an APB-style port; register 0 (byte 0) is timeout_ms.
//  Items are processed one at a time; req_ch.ready is high in idle only.
//  Processing steps:
//   tick, or drain with nothing pending: handled in idle, no result.
//   fragment byte: capture, then table lookup and RAM write.
//   drain byte: S_DBYTE, then S_EMIT when the piece continues; otherwise
//   the next pieces are scanned: S_SCAN per absent fragment, S_SCAN and
//   S_WAIT per held one. Completing fragment: capture, commit, a pass over
//   the session's fragments through the piece-length RAM port, then S_EMIT.
//  The result sits in an output register; the next item is taken while it
//  waits. A new result waits in its own state until the receiver takes the
//  previous one. Reset clears sessions and drain state and sets the timeout
//  to 1000. Both RAMs need no clearing: they are only read where written.
// ----------------------------------------------------------------------------
module fragment_reassembler
   import frr_pkg::*;
#(
   parameter int SESSIONS      = SESSIONS_DEF,
   parameter int MAX_FRAGMENTS = MAX_FRAGMENTS_DEF,
   parameter int MAX_PAYLOAD   = MAX_PAYLOAD_DEF
) (
   input  logic              clock,
   input  logic              reset,
   frr_req_if.sink           req_ch,
   frr_rsp_if.source         rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   localparam int SLOT_W   = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
   localparam int IDX_W    = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
   localparam int OFF_W    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int LEN_W    = $clog2(MAX_PAYLOAD + 1);
   localparam int PIECE_AW = SLOT_W + IDX_W;
   localparam int BYTE_AW  = PIECE_AW + OFF_W;
   localparam int SUM_W    = $clog2(MAX_FRAGMENTS * MAX_PAYLOAD + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FRAG  = 3'd1;
   localparam logic [2:0] S_DBYTE = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_WAIT  = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   // control
   logic [2:0]           state_ff, state_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic                 slot_active_ff [SESSIONS];
   logic                 slot_active_in [SESSIONS];
   logic                 in_fragment_ff, in_fragment_in;
   logic                 cur_skip_ff, cur_skip_in;
   logic                 drain_pending_ff, drain_pending_in;
   logic [SLOT_W-1:0]    drain_slot_ff, drain_slot_in;
   logic [IDX_W-1:0]     drain_index_ff, drain_index_in;
   logic [LEN_W-1:0]     drain_offset_ff, drain_offset_in;
   logic [LEN_W-1:0]     drain_len_ff, drain_len_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 sum_mode_ff, sum_mode_in;
   logic                 found_ff, found_in;

   // session table payload
   logic [15:0]              slot_seq_ff [SESSIONS];
   logic [15:0]              slot_seq_in [SESSIONS];
   logic [7:0]               slot_cmd_ff [SESSIONS];
   logic [7:0]               slot_cmd_in [SESSIONS];
   logic [CNT_W-1:0]         slot_total_ff [SESSIONS];
   logic [CNT_W-1:0]         slot_total_in [SESSIONS];
   logic [31:0]              slot_start_ff [SESSIONS];
   logic [31:0]              slot_start_in [SESSIONS];
   logic [MAX_FRAGMENTS-1:0] slot_mask_ff [SESSIONS];
   logic [MAX_FRAGMENTS-1:0] slot_mask_in [SESSIONS];
   logic [CNT_W-1:0]         slot_count_ff [SESSIONS];
   logic [CNT_W-1:0]         slot_count_in [SESSIONS];

   // current fragment
   logic [SLOT_W-1:0] cur_slot_ff, cur_slot_in;
   logic [IDX_W-1:0]  cur_index_ff, cur_index_in;
   logic [LEN_W-1:0]  cur_off_ff, cur_off_in;
   logic [LEN_W-1:0]  cur_len_ff, cur_len_in;

   // captured item
   logic [15:0]       it_seq_ff, it_seq_in;
   logic [7:0]        it_cmd_ff, it_cmd_in;
   logic [4:0]        it_idx_ff, it_idx_in;
   logic [CNT_W-1:0]  it_cnt_ff, it_cnt_in;
   logic [FLEN_W-1:0] it_len_ff, it_len_in;
   logic [7:0]        it_byte_ff, it_byte_in;
   logic              it_last_ff, it_last_in;
   logic [31:0]       it_now_ff, it_now_in;

   // scan / pending result
   logic [CNT_W-1:0]    j_ff, j_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   kind_type            pend_kind_ff, pend_kind_in;
   logic [15:0]         pend_seq_ff, pend_seq_in;
   logic [7:0]          pend_cmd_ff, pend_cmd_in;
   logic [MSGLEN_W-1:0] pend_len_ff, pend_len_in;
   logic [7:0]          pend_byte_ff, pend_byte_in;
   logic                pend_last_ff, pend_last_in;

   // output register
   kind_type            out_kind_ff, out_kind_in;
   logic [15:0]         out_seq_ff, out_seq_in;
   logic [7:0]          out_cmd_ff, out_cmd_in;
   logic [MSGLEN_W-1:0] out_len_ff, out_len_in;
   logic [7:0]          out_byte_ff, out_byte_in;
   logic                out_last_ff, out_last_in;

   // RAM ports
   logic                byte_we;
   logic [BYTE_AW-1:0]  byte_waddr, byte_raddr;
   logic [7:0]          byte_wdata, byte_rdata;
   logic                len_we;
   logic [PIECE_AW-1:0] len_waddr, len_raddr;
   logic [LEN_W-1:0]    len_wdata, len_rdata;

   frr_ram #(.WIDTH(8), .DEPTH(2 ** BYTE_AW)) u_bytes (
      .clock(clock), .wr_en(byte_we), .wr_addr(byte_waddr), .wr_data(byte_wdata),
      .rd_addr(byte_raddr), .rd_data(byte_rdata)
   );

   frr_ram #(.WIDTH(LEN_W), .DEPTH(2 ** PIECE_AW)) u_lengths (
      .clock(clock), .wr_en(len_we), .wr_addr(len_waddr), .wr_data(len_wdata),
      .rd_addr(len_raddr), .rd_data(len_rdata)
   );

   // APB register port
   logic csr_wr;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_TIMEOUT) ? {16'd0, timeout_ff} : 32'd0;
   // paddr[1:0] are byte lanes within the word; only the word select decodes

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = out_kind_ff;
   assign rsp_ch.msg_seq     = out_seq_ff;
   assign rsp_ch.msg_command = out_cmd_ff;
   assign rsp_ch.msg_length  = out_len_ff;
   assign rsp_ch.data_byte   = out_byte_ff;
   assign rsp_ch.data_last   = out_last_ff;

   always_comb begin
      logic              hit, has_free, opened, bad_hdr, drop, done, e_skip, e_act;
      logic [SLOT_W-1:0] hit_slot, free_slot, old_slot, e_slot;
      logic [IDX_W-1:0]  e_idx;
      logic [LEN_W-1:0]  e_off, e_len, off_next;
      logic [31:0]       age, best;
      logic [MAX_FRAGMENTS-1:0] base_mask;
      logic [CNT_W-1:0]  base_count, cnt_new, e_total;

      state_in         = state_ff;
      timeout_in       = timeout_ff;
      in_fragment_in   = in_fragment_ff;
      cur_skip_in      = cur_skip_ff;
      drain_pending_in = drain_pending_ff;
      drain_slot_in    = drain_slot_ff;
      drain_index_in   = drain_index_ff;
      drain_offset_in  = drain_offset_ff;
      drain_len_in     = drain_len_ff;
      sum_mode_in      = sum_mode_ff;
      found_in         = found_ff;
      for (int i = 0; i < SESSIONS; i++) begin
         slot_active_in[i] = slot_active_ff[i];
         slot_seq_in[i]    = slot_seq_ff[i];
         slot_cmd_in[i]    = slot_cmd_ff[i];
         slot_total_in[i]  = slot_total_ff[i];
         slot_start_in[i]  = slot_start_ff[i];
         slot_mask_in[i]   = slot_mask_ff[i];
         slot_count_in[i]  = slot_count_ff[i];
      end
      cur_slot_in  = cur_slot_ff;
      cur_index_in = cur_index_ff;
      cur_off_in   = cur_off_ff;
      cur_len_in   = cur_len_ff;
      it_seq_in    = it_seq_ff;
      it_cmd_in    = it_cmd_ff;
      it_idx_in    = it_idx_ff;
      it_cnt_in    = it_cnt_ff;
      it_len_in    = it_len_ff;
      it_byte_in   = it_byte_ff;
      it_last_in   = it_last_ff;
      it_now_in    = it_now_ff;
      j_in         = j_ff;
      acc_in       = acc_ff;
      pend_kind_in = pend_kind_ff;
      pend_seq_in  = pend_seq_ff;
      pend_cmd_in  = pend_cmd_ff;
      pend_len_in  = pend_len_ff;
      pend_byte_in = pend_byte_ff;
      pend_last_in = pend_last_ff;
      out_kind_in  = out_kind_ff;
      out_seq_in   = out_seq_ff;
      out_cmd_in   = out_cmd_ff;
      out_len_in   = out_len_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      byte_we    = 1'b0;
      byte_waddr = '0;
      byte_wdata = it_byte_ff;
      byte_raddr = {drain_slot_ff, drain_index_ff, drain_offset_ff[OFF_W-1:0]};
      len_we     = 1'b0;
      len_waddr  = '0;
      len_wdata  = '0;
      len_raddr  = {drain_slot_ff, j_ff[IDX_W-1:0]};

      hit = 1'b0; has_free = 1'b0; opened = 1'b0; bad_hdr = 1'b0; drop = 1'b0;
      done = 1'b0; e_skip = 1'b0; e_act = 1'b0;
      hit_slot = '0; free_slot = '0; old_slot = '0; e_slot = '0; e_idx = '0;
      e_off = '0; e_len = '0; off_next = '0; age = '0; best = '0;
      base_mask = '0; base_count = '0; cnt_new = '0; e_total = '0;

      if (csr_wr && csr_paddr[2] == CSR_IDX_TIMEOUT) begin
         timeout_in = csr_pwdata[TIMEOUT_W-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               unique case (req_ch.req_type)
                  REQ_TICK: begin
                     for (int i = 0; i < SESSIONS; i++) begin
                        if (slot_active_ff[i] &&
                            (req_ch.now_ms - slot_start_ff[i]) > {16'd0, timeout_ff}) begin
                           slot_active_in[i] = 1'b0;
                        end
                     end
                  end
                  REQ_DRAIN: begin
                     // byte read issued now from the drain position
                     if (drain_pending_ff) begin
                        state_in = S_DBYTE;
                     end
                  end
                  REQ_FRAG: begin
                     it_seq_in  = req_ch.seq_number;
                     it_cmd_in  = req_ch.command;
                     it_idx_in  = req_ch.frag_index;
                     it_cnt_in  = req_ch.frag_count;
                     it_len_in  = req_ch.frag_length;
                     it_byte_in = req_ch.payload_byte;
                     it_last_in = req_ch.byte_last;
                     it_now_in  = req_ch.now_ms;
                     state_in   = S_FRAG;
                  end
                  default: ;
               endcase
            end
         end

         S_FRAG: begin
            e_slot  = cur_slot_ff;
            e_idx   = cur_index_ff;
            e_off   = cur_off_ff;
            e_len   = cur_len_ff;
            e_skip  = cur_skip_ff;
            e_act   = slot_active_ff[cur_slot_ff];
            base_mask  = slot_mask_ff[cur_slot_ff];
            base_count = slot_count_ff[cur_slot_ff];
            e_total    = slot_total_ff[cur_slot_ff];

            if (!in_fragment_ff) begin
               in_fragment_in = 1'b1;
               e_skip  = 1'b1;
               bad_hdr = ({1'b0, it_idx_ff} >= it_cnt_ff) ||
                         (it_cnt_ff > CNT_W'(MAX_FRAGMENTS)) || (it_cnt_ff == '0);
               if (bad_hdr) begin
                  drop = 1'b1;
               end else begin
                  // session lookup: same seq, else lowest free, else oldest
                  for (int i = 0; i < SESSIONS; i++) begin
                     age = it_now_ff - slot_start_ff[i];
                     if (slot_active_ff[i] && slot_seq_ff[i] == it_seq_ff && !hit) begin
                        hit = 1'b1;
                        hit_slot = SLOT_W'(i);
                     end
                     if (!slot_active_ff[i] && !has_free) begin
                        has_free = 1'b1;
                        free_slot = SLOT_W'(i);
                     end
                     if (i == 0 || age > best) begin
                        best = age;
                        old_slot = SLOT_W'(i);
                     end
                  end
                  e_slot = hit ? hit_slot : (has_free ? free_slot : old_slot);
                  opened = !hit;
                  if (opened) begin
                     slot_active_in[e_slot] = 1'b1;
                     slot_seq_in[e_slot]    = it_seq_ff;
                     slot_cmd_in[e_slot]    = it_cmd_ff;
                     slot_total_in[e_slot]  = it_cnt_ff;
                     slot_start_in[e_slot]  = it_now_ff;
                     slot_mask_in[e_slot]   = '0;
                     slot_count_in[e_slot]  = '0;
                     if (drain_pending_ff && drain_slot_ff == e_slot) begin
                        drain_pending_in = 1'b0;
                     end
                     base_mask  = '0;
                     base_count = '0;
                     e_total    = it_cnt_ff;
                  end else begin
                     base_mask  = slot_mask_ff[e_slot];
                     base_count = slot_count_ff[e_slot];
                     e_total    = slot_total_ff[e_slot];
                  end
                  e_idx = it_idx_ff[IDX_W-1:0];
                  e_off = '0;
                  e_act = 1'b1;
                  if (!base_mask[e_idx]) begin
                     if (32'(it_len_ff) > MAX_PAYLOAD) begin
                        drop = 1'b1;
                     end else begin
                        e_skip = 1'b0;
                        e_len  = LEN_W'(it_len_ff);
                     end
                  end
               end
            end

            if (!e_skip && e_off < e_len) begin
               byte_we    = 1'b1;
               byte_waddr = {e_slot, e_idx, e_off[OFF_W-1:0]};
               e_off      = e_off + LEN_W'(1);
            end

            cur_slot_in  = e_slot;
            cur_index_in = e_idx;
            cur_off_in   = e_off;
            cur_len_in   = e_len;
            cur_skip_in  = e_skip;
            state_in     = S_IDLE;

            if (it_last_ff) begin
               in_fragment_in = 1'b0;
               cur_skip_in    = 1'b0;
               if (!e_skip && e_act) begin
                  // commit: the piece length is what actually arrived
                  len_we    = 1'b1;
                  len_waddr = {e_slot, e_idx};
                  len_wdata = e_off;
                  slot_mask_in[e_slot] = base_mask | (MAX_FRAGMENTS'(1) << e_idx);
                  cnt_new = base_count + CNT_W'(1);
                  slot_count_in[e_slot] = cnt_new;
                  if (cnt_new >= e_total) begin
                     slot_active_in[e_slot] = 1'b0;
                     drain_slot_in = e_slot;
                     sum_mode_in   = 1'b1;
                     found_in      = 1'b0;
                     acc_in        = '0;
                     j_in          = '0;
                     state_in      = S_SCAN;
                  end
               end
            end

            if (drop) begin
               pend_kind_in = KIND_DROP;
               pend_seq_in  = it_seq_ff;
               pend_cmd_in  = it_cmd_ff;
               pend_len_in  = '0;
               pend_byte_in = '0;
               pend_last_in = 1'b0;
               state_in     = S_EMIT;
            end
         end

         S_DBYTE: begin
            pend_kind_in = KIND_DATA;
            pend_seq_in  = slot_seq_ff[drain_slot_ff];
            pend_cmd_in  = slot_cmd_ff[drain_slot_ff];
            pend_len_in  = '0;
            pend_byte_in = byte_rdata;
            off_next     = drain_offset_ff + LEN_W'(1);
            if (off_next < drain_len_ff) begin
               drain_offset_in = off_next;
               pend_last_in    = 1'b0;
               state_in        = S_EMIT;
            end else begin
               j_in        = CNT_W'(drain_index_ff) + CNT_W'(1);
               sum_mode_in = 1'b0;
               state_in    = S_SCAN;
            end
         end

         S_SCAN: begin
            if (j_ff < slot_total_ff[drain_slot_ff] && j_ff < CNT_W'(MAX_FRAGMENTS)) begin
               if (slot_mask_ff[drain_slot_ff][j_ff[IDX_W-1:0]]) begin
                  state_in = S_WAIT;   // length read issued this cycle
               end else begin
                  j_in = j_ff + CNT_W'(1);
               end
            end else begin
               state_in = S_EMIT;
               if (sum_mode_ff) begin
                  drain_pending_in = found_ff;
                  pend_kind_in = KIND_COMPLETE;
                  pend_seq_in  = slot_seq_ff[drain_slot_ff];
                  pend_cmd_in  = slot_cmd_ff[drain_slot_ff];
                  pend_len_in  = (32'(acc_ff) > MSGLEN_MAX) ? MSGLEN_W'(MSGLEN_MAX)
                                                            : MSGLEN_W'(acc_ff);
                  pend_byte_in = '0;
                  pend_last_in = 1'b0;
               end else begin
                  drain_pending_in = 1'b0;
                  pend_last_in     = 1'b1;
               end
            end
         end

         S_WAIT: begin
            j_in     = j_ff + CNT_W'(1);
            state_in = S_SCAN;
            if (sum_mode_ff) begin
               acc_in = acc_ff + SUM_W'(len_rdata);
               if (len_rdata != '0 && !found_ff) begin
                  found_in        = 1'b1;
                  drain_index_in  = j_ff[IDX_W-1:0];
                  drain_offset_in = '0;
                  drain_len_in    = len_rdata;
               end
            end else if (len_rdata != '0) begin
               drain_index_in  = j_ff[IDX_W-1:0];
               drain_offset_in = '0;
               drain_len_in    = len_rdata;
               pend_last_in    = 1'b0;
               state_in        = S_EMIT;
            end
         end

         S_EMIT: begin
            done = !rsp_valid_ff || rsp_ch.ready;
            if (done) begin
               out_kind_in  = pend_kind_ff;
               out_seq_in   = pend_seq_ff;
               out_cmd_in   = pend_cmd_ff;
               out_len_in   = pend_len_ff;
               out_byte_in  = pend_byte_ff;
               out_last_in  = pend_last_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         timeout_ff       <= TIMEOUT_RESET;
         in_fragment_ff   <= 1'b0;
         cur_skip_ff      <= 1'b0;
         drain_pending_ff <= 1'b0;
         drain_slot_ff    <= '0;
         drain_index_ff   <= '0;
         drain_offset_ff  <= '0;
         drain_len_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
         sum_mode_ff      <= 1'b0;
         found_ff         <= 1'b0;
         cur_slot_ff      <= '0;
         cur_index_ff     <= '0;
         cur_off_ff       <= '0;
         cur_len_ff       <= '0;
         for (int i = 0; i < SESSIONS; i++) begin
            slot_active_ff[i] <= 1'b0;
         end
      end else begin
         state_ff         <= state_in;
         timeout_ff       <= timeout_in;
         in_fragment_ff   <= in_fragment_in;
         cur_skip_ff      <= cur_skip_in;
         drain_pending_ff <= drain_pending_in;
         drain_slot_ff    <= drain_slot_in;
         drain_index_ff   <= drain_index_in;
         drain_offset_ff  <= drain_offset_in;
         drain_len_ff     <= drain_len_in;
         rsp_valid_ff     <= rsp_valid_in;
         sum_mode_ff      <= sum_mode_in;
         found_ff         <= found_in;
         cur_slot_ff      <= cur_slot_in;
         cur_index_ff     <= cur_index_in;
         cur_off_ff       <= cur_off_in;
         cur_len_ff       <= cur_len_in;
         for (int i = 0; i < SESSIONS; i++) begin
            slot_active_ff[i] <= slot_active_in[i];
         end
      end
   end

   // payload: only read once written under an active or completed session
   always_ff @(posedge clock) begin
      for (int i = 0; i < SESSIONS; i++) begin
         slot_seq_ff[i]   <= slot_seq_in[i];
         slot_cmd_ff[i]   <= slot_cmd_in[i];
         slot_total_ff[i] <= slot_total_in[i];
         slot_start_ff[i] <= slot_start_in[i];
         slot_mask_ff[i]  <= slot_mask_in[i];
         slot_count_ff[i] <= slot_count_in[i];
      end
      it_seq_ff    <= it_seq_in;
      it_cmd_ff    <= it_cmd_in;
      it_idx_ff    <= it_idx_in;
      it_cnt_ff    <= it_cnt_in;
      it_len_ff    <= it_len_in;
      it_byte_ff   <= it_byte_in;
      it_last_ff   <= it_last_in;
      it_now_ff    <= it_now_in;
      j_ff         <= j_in;
      acc_ff       <= acc_in;
      pend_kind_ff <= pend_kind_in;
      pend_seq_ff  <= pend_seq_in;
      pend_cmd_ff  <= pend_cmd_in;
      pend_len_ff  <= pend_len_in;
      pend_byte_ff <= pend_byte_in;
      pend_last_ff <= pend_last_in;
      out_kind_ff  <= out_kind_in;
      out_seq_ff   <= out_seq_in;
      out_cmd_ff   <= out_cmd_in;
      out_len_ff   <= out_len_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
   end

   // a pending drain always points at a nonempty piece
   a_drain_len: assert property (@(posedge clock) disable iff (reset)
      drain_pending_ff |-> drain_len_ff != '0)
      else $error("drain pending on empty piece");

   // the slot being drained is closed; reopening it cancels the drain
   a_drain_closed: assert property (@(posedge clock) disable iff (reset)
      drain_pending_ff |-> !slot_active_ff[drain_slot_ff])
      else $error("drain pending on an open session");

   // write offset never passes the fragment length
   a_offset: assert property (@(posedge clock) disable iff (reset)
      (in_fragment_ff && !cur_skip_ff) |-> cur_off_ff <= cur_len_ff)
      else $error("fragment offset beyond length");

endmodule
